/* hw/rtl/tkst_pkg.sv */
package tkst_pkg;

    localparam int SCORE_W   = 32;
    localparam int COMBO_W   = 16;
    localparam int NAME_W    = 48;
    localparam int RANK_W    = 4;
    localparam int CHAR_BITS = 6;

    localparam logic [CHAR_BITS-1:0] BLANK_CHAR = 6'd37;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [COMBO_W-1:0] combo;
        logic [NAME_W-1:0]  name;
    } t_entry;

    function automatic logic outranks(t_entry cand, t_entry held);
        logic res;
        if (cand.score != held.score) begin
            res = cand.score > held.score;
        end else begin
            res = cand.combo >= held.combo;
        end
        return res;
    endfunction

endpackage

/* hw/rtl/tkst_cell.sv */
module tkst_cell
    import tkst_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [NAME_W-1:0] i_blank_name,
    input  logic         i_wr,
    input  t_entry       i_new,
    input  t_entry       i_prev,
    input  logic         i_prev_outranks,
    output t_entry       o_entry,
    output logic         o_outranks
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_entry    = r_entry;
    assign o_outranks = outranks(i_new, r_entry);

    always_comb begin
        n_entry = r_entry;
        if (i_wr && o_outranks) begin
            n_entry = i_prev_outranks ? i_prev : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.score <= '0;
            r_entry.combo <= '0;
            r_entry.name  <= i_blank_name;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

/* hw/rtl/top_k_score_table_insert.sv */
// Sorted table of the best TABLE_ENTRIES records (score, then combo).
// Input channel: i_valid / o_stall carries one item per transfer. An insert
// (i_operation 0) enters the table only if its score beats the last entry;
// the record lands below every entry that it does not outrank (on a full
// tie it goes above the held entry), lower entries move down one cell and
// the last drops out. A read (i_operation 1) returns the entry at
// i_read_index, clamped to the last rank. Output channel: o_valid / i_stall
// carries one result per item. o_valid rises in the cycle after an input
// transfer; one item per cycle is taken while o_stall is low. Each table row
// is a cell that compares the offered record with its own entry and loads
// either the record or its upper neighbor in that cycle. The output register
// holds a result while i_stall is high; o_stall then rises and the table
// stays untouched until the result transfers. Reset clears every score and
// combo to zero, fills each name character with code 37 and clears o_valid.
module top_k_score_table_insert
    import tkst_pkg::*;
#(
    parameter int TABLE_ENTRIES = 10,
    parameter int NAME_LENGTH   = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic [SCORE_W-1:0] i_new_score,
    input  logic [COMBO_W-1:0] i_new_combo,
    input  logic [NAME_W-1:0]  i_new_name,
    input  logic [RANK_W-1:0]  i_read_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_accepted,
    output logic [RANK_W-1:0]  o_rank,
    output logic [NAME_W-1:0]  o_entry_name,
    output logic [COMBO_W-1:0] o_entry_combo,
    output logic [SCORE_W-1:0] o_entry_score
);

    localparam int LAST       = TABLE_ENTRIES - 1;
    localparam int IDX_W      = $clog2(TABLE_ENTRIES);
    localparam int CMP_W      = (IDX_W > RANK_W) ? IDX_W : RANK_W;
    localparam int STORED_W   = (CHAR_BITS * NAME_LENGTH < NAME_W) ?
                                CHAR_BITS * NAME_LENGTH : NAME_W;
    localparam int NAME_CHARS = STORED_W / CHAR_BITS;
    localparam logic [NAME_W-1:0] NAME_MASK = (STORED_W == NAME_W) ? {NAME_W{1'b1}} :
                                              ((NAME_W'(1) << STORED_W) - NAME_W'(1));

    logic [NAME_W-1:0] w_blank;
    t_entry            w_new;
    t_entry            w_entry    [TABLE_ENTRIES];
    logic              w_outranks [TABLE_ENTRIES];
    logic              w_fire;
    logic              w_take;
    logic              w_wr;
    logic [CMP_W-1:0]  w_pos;
    logic [CMP_W-1:0]  w_ridx;
    logic [IDX_W-1:0]  w_rsel;

    logic               r_valid;
    logic               r_accepted;
    logic [RANK_W-1:0]  r_rank;
    logic [NAME_W-1:0]  r_name;
    logic [COMBO_W-1:0] r_combo;
    logic [SCORE_W-1:0] r_score;

    always_comb begin
        w_blank = '0;
        for (int c = 0; c < NAME_CHARS; c++) begin
            w_blank[c*CHAR_BITS +: CHAR_BITS] = BLANK_CHAR;
        end
    end

    assign w_new.score = i_new_score;
    assign w_new.combo = i_new_combo;
    assign w_new.name  = i_new_name & NAME_MASK;

    assign o_stall = r_valid && i_stall;
    assign w_fire  = i_valid && !o_stall;
    assign w_take  = (t_op'(i_operation) == OP_INSERT) && (i_new_score > w_entry[LAST].score);
    assign w_wr    = w_fire && w_take;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            if (g == 0) begin : g_head
                tkst_cell u_cell (
                    .i_clk           (i_clk),
                    .i_rst_n         (i_rst_n),
                    .i_blank_name    (w_blank),
                    .i_wr            (w_wr),
                    .i_new           (w_new),
                    .i_prev          (w_new),
                    .i_prev_outranks (1'b0),
                    .o_entry         (w_entry[g]),
                    .o_outranks      (w_outranks[g])
                );
            end else begin : g_body
                tkst_cell u_cell (
                    .i_clk           (i_clk),
                    .i_rst_n         (i_rst_n),
                    .i_blank_name    (w_blank),
                    .i_wr            (w_wr),
                    .i_new           (w_new),
                    .i_prev          (w_entry[g-1]),
                    .i_prev_outranks (w_outranks[g-1]),
                    .o_entry         (w_entry[g]),
                    .o_outranks      (w_outranks[g])
                );
            end
        end
    endgenerate

    always_comb begin
        w_pos = CMP_W'(LAST);
        for (int i = LAST; i >= 0; i--) begin
            if (w_outranks[i]) begin
                w_pos = CMP_W'(i);
            end
        end
    end

    always_comb begin
        w_ridx = CMP_W'(i_read_index);
        if (w_ridx > CMP_W'(LAST)) begin
            w_ridx = CMP_W'(LAST);
        end
        w_rsel = w_ridx[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_fire) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (t_op'(i_operation) == OP_READ) begin
                r_accepted <= 1'b0;
                r_rank     <= w_ridx[RANK_W-1:0];
                r_name     <= w_entry[w_rsel].name;
                r_combo    <= w_entry[w_rsel].combo;
                r_score    <= w_entry[w_rsel].score;
            end else if (w_take) begin
                r_accepted <= 1'b1;
                r_rank     <= w_pos[RANK_W-1:0];
                r_name     <= w_new.name;
                r_combo    <= w_new.combo;
                r_score    <= w_new.score;
            end else begin
                r_accepted <= 1'b0;
                r_rank     <= '0;
                r_name     <= '0;
                r_combo    <= '0;
                r_score    <= '0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_accepted    = r_accepted;
    assign o_rank        = r_rank;
    assign o_entry_name  = r_name;
    assign o_entry_combo = r_combo;
    assign o_entry_score = r_score;

endmodule

/* test/tb_top_k_score_table_insert.sv */
`timescale 1ns / 100ps

module tb_top_k_score_table_insert;
    import tkst_pkg::*;

    localparam int ROWS         = 10;
    localparam int LAST_ROW     = ROWS - 1;
    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_ITEMS = 160;
    localparam int PHASES       = 4;
    localparam int SHOWN_ERRORS = 10;

    localparam logic [SCORE_W-1:0] TOP_SCORE = '1;
    localparam logic [COMBO_W-1:0] TOP_COMBO = '1;
    localparam logic [NAME_W-1:0]  ODD_NAME  = 48'hAAAA_AAAA_AAAA;
    localparam logic [NAME_W-1:0]  EVEN_NAME = 48'h5555_5555_5555;

    typedef struct packed {
        logic               accepted;
        logic [RANK_W-1:0]  rank;
        logic [NAME_W-1:0]  name;
        logic [COMBO_W-1:0] combo;
        logic [SCORE_W-1:0] score;
    } t_table_result;

    class ranking_board;
        t_entry        rows[ROWS];
        t_table_result pending[$];
        int            mismatches;

        function new();
            logic [NAME_W-1:0] blank;
            blank = '0;
            for (int c = 0; c < NAME_W / CHAR_BITS; c++) begin
                blank[c*CHAR_BITS +: CHAR_BITS] = BLANK_CHAR;
            end
            foreach (rows[r]) begin
                rows[r].score = '0;
                rows[r].combo = '0;
                rows[r].name  = blank;
            end
            mismatches = 0;
        endfunction

        function bit ranks_above(t_entry cand, t_entry held);
            if (cand.score != held.score) begin
                return cand.score > held.score;
            end
            return cand.combo >= held.combo;
        endfunction

        function void note_item(t_op op, logic [SCORE_W-1:0] score,
                                logic [COMBO_W-1:0] combo, logic [NAME_W-1:0] name,
                                logic [RANK_W-1:0] read_at);
            t_table_result res;
            t_entry        fresh;
            int            slot;
            res = '0;
            if (op == OP_READ) begin
                slot      = (read_at > LAST_ROW) ? LAST_ROW : int'(read_at);
                res.rank  = RANK_W'(slot);
                res.name  = rows[slot].name;
                res.combo = rows[slot].combo;
                res.score = rows[slot].score;
            end else if (score > rows[LAST_ROW].score) begin
                fresh.score = score;
                fresh.combo = combo;
                fresh.name  = name;
                slot = LAST_ROW;
                while (slot > 0 && ranks_above(fresh, rows[slot-1])) begin
                    slot--;
                end
                for (int r = LAST_ROW; r > slot; r--) begin
                    rows[r] = rows[r-1];
                end
                rows[slot]   = fresh;
                res.accepted = 1'b1;
                res.rank     = RANK_W'(slot);
                res.name     = name;
                res.combo    = combo;
                res.score    = score;
            end
            pending.push_back(res);
        endfunction

        function void flag(string what, t_table_result want, t_table_result got);
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
                $display("%0t %s: expected acc=%0b rank=%0d name=%h combo=%h score=%h",
                         $realtime, what, want.accepted, want.rank, want.name,
                         want.combo, want.score);
                $display("    got acc=%0b rank=%0d name=%h combo=%h score=%h",
                         got.accepted, got.rank, got.name, got.combo, got.score);
            end
        endfunction

        function void check_result(t_table_result got);
            t_table_result want;
            if (pending.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            want = pending.pop_front();
            if (got.accepted !== want.accepted || got.rank !== want.rank ||
                got.name !== want.name || got.combo !== want.combo ||
                got.score !== want.score) begin
                flag("result mismatch", want, got);
            end
        endfunction
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               i_stall      = 1'b0;
    logic               i_operation  = 1'b0;
    logic [SCORE_W-1:0] i_new_score  = '0;
    logic [COMBO_W-1:0] i_new_combo  = '0;
    logic [NAME_W-1:0]  i_new_name   = '0;
    logic [RANK_W-1:0]  i_read_index = '0;
    logic               o_stall;
    logic               o_valid;
    logic               o_accepted;
    logic [RANK_W-1:0]  o_rank;
    logic [NAME_W-1:0]  o_entry_name;
    logic [COMBO_W-1:0] o_entry_combo;
    logic [SCORE_W-1:0] o_entry_score;

    ranking_board board = new();
    int           idle_pct     = 0;
    int           stall_pct    = 0;
    int           quiet_cycles = 0;

    top_k_score_table_insert dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_new_score   (i_new_score),
        .i_new_combo   (i_new_combo),
        .i_new_name    (i_new_name),
        .i_read_index  (i_read_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_accepted    (o_accepted),
        .o_rank        (o_rank),
        .o_entry_name  (o_entry_name),
        .o_entry_combo (o_entry_combo),
        .o_entry_score (o_entry_score)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            board.note_item(t_op'(i_operation), i_new_score, i_new_combo, i_new_name,
                            i_read_index);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_result('{o_accepted, o_rank, o_entry_name, o_entry_combo,
                                 o_entry_score});
        end
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall))) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("top_k_score_table_insert regression: fail");
            $finish;
        end
    end

    task automatic send_item(t_op op, logic [SCORE_W-1:0] score, logic [COMBO_W-1:0] combo,
                             logic [NAME_W-1:0] name, logic [RANK_W-1:0] read_at);
        bit done;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_new_score  <= score;
        i_new_combo  <= combo;
        i_new_name   <= name;
        i_read_index <= read_at;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            done = !o_stall;
            @(negedge i_clk);
        end
    endtask

    task automatic random_item();
        logic [SCORE_W-1:0] score;
        logic [COMBO_W-1:0] combo;
        logic [63:0]        wide;
        t_op                op;
        int                 pick;
        int                 row;
        wide  = {$urandom(), $urandom()};
        combo = COMBO_W'($urandom_range(16'hFFFF));
        row   = $urandom_range(LAST_ROW);
        pick  = $urandom_range(99);
        op    = ($urandom_range(9) < 3) ? OP_READ : OP_INSERT;
        if (pick < 35) begin
            score = board.rows[row].score;
            if ($urandom_range(1) == 1) begin
                combo = board.rows[row].combo;
            end
        end else if (pick < 60) begin
            score = board.rows[row].score + $urandom_range(6) - 3;
        end else if (pick < 75) begin
            score = board.rows[LAST_ROW].score + $urandom_range(1);
        end else if (pick < 90) begin
            score = $urandom();
        end else begin
            score = $urandom_range(20);
        end
        if ($urandom_range(9) == 0) begin
            combo = ($urandom_range(1) == 1) ? TOP_COMBO : '0;
        end
        send_item(op, score, combo, wide[NAME_W-1:0], RANK_W'($urandom_range(15)));
    endtask

    initial begin
        static int phase_idle[PHASES]  = '{0, 66, 0, 16};
        static int phase_stall[PHASES] = '{0, 0, 66, 16};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(OP_READ, '0, '0, '0, 4'd0);
        send_item(OP_READ, '0, '0, '0, 4'd9);
        send_item(OP_READ, '0, '0, '0, 4'd10);
        send_item(OP_READ, '0, '0, '0, 4'd15);
        send_item(OP_INSERT, '0, TOP_COMBO, '1, 4'd0);
        send_item(OP_INSERT, 32'd1, '0, '1, 4'd15);
        send_item(OP_INSERT, TOP_SCORE, TOP_COMBO, '0, 4'd0);
        send_item(OP_INSERT, TOP_SCORE, '0, ODD_NAME, 4'd0);
        send_item(OP_INSERT, TOP_SCORE, TOP_COMBO, EVEN_NAME, 4'd0);
        send_item(OP_INSERT, 32'd5, 16'd7, ODD_NAME, 4'd0);
        send_item(OP_INSERT, 32'd5, 16'd7, EVEN_NAME, 4'd0);
        send_item(OP_INSERT, 32'd5, 16'd6, '1, 4'd0);
        send_item(OP_INSERT, 32'd2, '0, 48'h1, 4'd0);
        send_item(OP_INSERT, 32'd2, '0, 48'h2, 4'd0);
        send_item(OP_INSERT, 32'd2, '0, 48'h3, 4'd0);
        send_item(OP_INSERT, 32'd1, TOP_COMBO, 48'h4, 4'd0);
        send_item(OP_INSERT, 32'd2, '0, 48'h5, 4'd0);
        send_item(OP_READ, TOP_SCORE, TOP_COMBO, '1, 4'd0);
        send_item(OP_READ, '0, '0, '0, 4'd6);
        send_item(OP_READ, '0, '0, '0, 4'd9);
        send_item(OP_READ, '0, '0, '0, 4'd15);

        for (int p = 0; p < PHASES; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            repeat (RANDOM_ITEMS) random_item();
        end

        i_valid   <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("top_k_score_table_insert regression: pass");
        end else begin
            $display("top_k_score_table_insert regression: fail");
        end
        $finish;
    end

endmodule
